FILE: hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, compiled out for synthesis
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property that must hold at every clock edge out of reset
`define DQ_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
		else $error("assertion failed");

// antecedent implies consequent in the same cycle
`define DQ_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define DQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");

`else

`define DQ_ASSERT(lbl, clk, rst_n, prop)
`define DQ_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define DQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

FILE: hw/rtl/dq_pkg.sv
// ---------------------------------------------------------------------------
// dq_pkg
// shared types and constants of the double-ended queue
// ---------------------------------------------------------------------------
package dq_pkg;

	// number of entry cells
	localparam int DEPTH = 16;
	// count width, able to hold DEPTH itself
	localparam int CNT_W = $clog2(DEPTH + 1);
	// width of the occupancy field
	localparam int OCC_W = 5;
	localparam int WORD_W = 32;

	typedef logic signed [WORD_W-1:0] word_t;
	typedef logic [CNT_W-1:0] cnt_t;

	typedef enum logic [1:0] {
		OP_PUSH_FRONT = 2'd0,
		OP_PUSH_BACK  = 2'd1,
		OP_POP_FRONT  = 2'd2,
		OP_POP_BACK   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// control broadcast to every cell
	typedef struct packed {
		logic push_front;
		logic pop_front;
		logic push_back;
		cnt_t count;
	} cell_ctrl_t;

endpackage

FILE: hw/rtl/dq_req_if.sv
// ---------------------------------------------------------------------------
// dq_req_if
// request channel: one queue operation per transaction
// ---------------------------------------------------------------------------
interface dq_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  operation;
	logic signed [31:0] item_value;

	modport source (output valid, output operation, output item_value, input ready);
	modport sink (input valid, input operation, input item_value, output ready);
endinterface

FILE: hw/rtl/dq_rsp_if.sv
// ---------------------------------------------------------------------------
// dq_rsp_if
// response channel: one result per request transaction
// ---------------------------------------------------------------------------
interface dq_rsp_if;
	logic        valid;
	logic        ready;
	logic signed [31:0] popped_value;
	logic [1:0]  status;
	logic [4:0]  occupancy;

	modport source (output valid, output popped_value, output status, output occupancy,
		input ready);
	modport sink (input valid, input popped_value, input status, input occupancy,
		output ready);
endinterface

FILE: hw/rtl/double_ended_queue.sv
// ---------------------------------------------------------------------------
// double_ended_queue
// bounded deque of signed words held in a chain of shifting cells
// ---------------------------------------------------------------------------
//
//  channel  direction  fields
//  req      in         operation, item_value
//  rsp      out        popped_value, status, occupancy
//
// one transaction per cycle while rsp drains the output register; the result appears
// in the output register the cycle after acceptance, as the cell chain updates
// the front entry always sits in cell 0; push/pop at the front shift all cells
// reset clears the entry count and the output valid; cell contents stay as is
// req is taken while the output register is empty or being drained
//
module double_ended_queue (
	input  logic    clk,
	input  logic    arst_n,
	dq_req_if.sink  req,
	dq_rsp_if.source rsp
);

	`include "assert_macros.svh"

	dq_pkg::cnt_t       count_q;
	dq_pkg::cnt_t       count_d;
	dq_pkg::cell_ctrl_t ctrl;
	dq_pkg::op_t        op;
	dq_pkg::status_t    status_d;
	dq_pkg::status_t    status_q;
	dq_pkg::word_t      popped_d;
	dq_pkg::word_t      popped_q;
	logic [dq_pkg::OCC_W-1:0] occ_q;
	logic               out_valid_q;
	logic               acc;
	logic               full;
	logic               empty;

	dq_pkg::word_t      word_w  [dq_pkg::DEPTH];
	dq_pkg::word_t      chain_w [dq_pkg::DEPTH+1];

	// handshake
	assign req.ready = !out_valid_q || rsp.ready;
	assign acc       = req.valid && req.ready;

	assign op    = dq_pkg::op_t'(req.operation);
	assign full  = (count_q == dq_pkg::CNT_W'(dq_pkg::DEPTH));
	assign empty = (count_q == '0);

	// operation decode
	always_comb begin
		ctrl.push_front = 1'b0;
		ctrl.pop_front  = 1'b0;
		ctrl.push_back  = 1'b0;
		ctrl.count      = count_q;
		status_d        = dq_pkg::ST_DONE;
		popped_d        = '0;
		count_d         = count_q;
		if (acc) begin
			unique case (op)
				dq_pkg::OP_PUSH_FRONT: begin
					if (full) begin
						status_d = dq_pkg::ST_FULL;
					end else begin
						ctrl.push_front = 1'b1;
						count_d = count_q + 1'b1;
					end
				end
				dq_pkg::OP_PUSH_BACK: begin
					if (full) begin
						status_d = dq_pkg::ST_FULL;
					end else begin
						ctrl.push_back = 1'b1;
						count_d = count_q + 1'b1;
					end
				end
				dq_pkg::OP_POP_FRONT: begin
					if (empty) begin
						status_d = dq_pkg::ST_EMPTY;
					end else begin
						ctrl.pop_front = 1'b1;
						popped_d = word_w[0];
						count_d = count_q - 1'b1;
					end
				end
				dq_pkg::OP_POP_BACK: begin
					if (empty) begin
						status_d = dq_pkg::ST_EMPTY;
					end else begin
						popped_d = chain_w[0];
						count_d = count_q - 1'b1;
					end
				end
				default: begin
					status_d = dq_pkg::ST_DONE;
				end
			endcase
		end
	end

	// cell chain
	assign chain_w[dq_pkg::DEPTH] = '0;

	for (genvar i = 0; i < dq_pkg::DEPTH; i++) begin : g_cell
		dq_pkg::word_t left_w;
		dq_pkg::word_t right_w;

		if (i == 0) begin : g_first
			assign left_w = req.item_value;
		end else begin : g_mid_l
			assign left_w = word_w[i-1];
		end

		if (i == dq_pkg::DEPTH - 1) begin : g_last
			assign right_w = word_w[i];
		end else begin : g_mid_r
			assign right_w = word_w[i+1];
		end

		dq_cell u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.index      (dq_pkg::CNT_W'(i)),
			.item_value (req.item_value),
			.left_word  (left_w),
			.right_word (right_w),
			.tail_in    (chain_w[i+1]),
			.tail_out   (chain_w[i]),
			.word       (word_w[i])
		);
	end

	// entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_d;
		end
	end

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (acc) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (acc) begin
			popped_q <= popped_d;
			status_q <= status_d;
			occ_q    <= dq_pkg::OCC_W'(count_d);
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.popped_value = popped_q;
	assign rsp.status       = status_q;
	assign rsp.occupancy    = occ_q;

	// checks
	`DQ_ASSERT(a_count_bound, clk, arst_n, count_q <= dq_pkg::CNT_W'(dq_pkg::DEPTH))
	`DQ_ASSERT_IMPL(a_occ_matches, clk, arst_n, out_valid_q,
		occ_q == dq_pkg::OCC_W'(count_q))
	`DQ_ASSERT_NEXT(a_push_grows, clk, arst_n,
		acc && !full && (op == dq_pkg::OP_PUSH_FRONT || op == dq_pkg::OP_PUSH_BACK),
		count_q == dq_pkg::CNT_W'($past(count_q) + 1'b1))
	`DQ_ASSERT_IMPL(a_empty_result, clk, arst_n,
		out_valid_q && status_q == dq_pkg::ST_EMPTY,
		popped_q == '0 && count_q == '0)
	`DQ_ASSERT_NEXT(a_acc_valid, clk, arst_n, acc, out_valid_q)

endmodule

FILE: hw/rtl/dq_cell.sv
// ---------------------------------------------------------------------------
// dq_cell
// one entry of the shift chain: shifts toward either end, loads at the tail
// ---------------------------------------------------------------------------
module dq_cell (
	input  logic                clk,
	input  dq_pkg::cell_ctrl_t  ctrl,
	input  dq_pkg::cnt_t        index,
	input  dq_pkg::word_t       item_value,
	input  dq_pkg::word_t       left_word,
	input  dq_pkg::word_t       right_word,
	input  dq_pkg::word_t       tail_in,
	output dq_pkg::word_t       tail_out,
	output dq_pkg::word_t       word
);

	dq_pkg::word_t word_q;
	dq_pkg::word_t word_d;
	logic          tail_hit;
	logic          load_hit;

	// this cell holds the back entry
	assign tail_hit = (dq_pkg::CNT_W'(index + 1'b1) == ctrl.count);
	// this cell is the first free slot
	assign load_hit = (index == ctrl.count);

	// next word: shift in from the front side, from the back side, load, or hold
	always_comb begin
		if (ctrl.push_front) begin
			word_d = left_word;
		end else if (ctrl.pop_front) begin
			word_d = right_word;
		end else if (ctrl.push_back && load_hit) begin
			word_d = item_value;
		end else begin
			word_d = word_q;
		end
	end

	always_ff @(posedge clk) begin
		word_q <= word_d;
	end

	// back entry select passed down the chain toward the front
	assign tail_out = tail_in | (tail_hit ? word_q : '0);
	assign word     = word_q;

endmodule
